FILE: hw/rtl/rdde_pkg.sv
// Shared types, constants and helper functions of the raster draw engine.
// Used by every module of the block but rdde_ram; depends on nothing else.
package rdde_pkg;

    // Screen geometry and the frame store address space.
    localparam int SCREEN_W = 320;
    localparam int SCREEN_H = 240;
    localparam int PIX_N    = SCREEN_W * SCREEN_H;
    localparam int ADDR_W   = $clog2(PIX_N);

    // Field and internal widths.
    localparam int OP_W    = 4;
    localparam int FLD_W   = 12;
    localparam int RAD_W   = 10;
    localparam int COLOR_W = 16;
    localparam int CRD_W   = 16;
    localparam int ERR_W   = 19;
    localparam int FRAC_W  = 16;
    localparam int DIVN_W  = FLD_W + FRAC_W;
    localparam int QX_W    = 32;
    localparam int SQ_W    = 2 * RAD_W;
    localparam int PART_W  = 3;

    typedef logic signed [CRD_W-1:0] crd_t;
    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic [COLOR_W-1:0]      color_t;
    typedef logic signed [QX_W-1:0]  qx_t;

    // Command codes carried in tuser.
    typedef enum logic [OP_W-1:0] {
        OP_PIXEL      = 4'd0,
        OP_RECT       = 4'd1,
        OP_SCREEN     = 4'd2,
        OP_CIRCLE     = 4'd3,
        OP_LINE       = 4'd4,
        OP_ROUND_LINE = 4'd5,
        OP_ROUND_FILL = 4'd6,
        OP_TRIANGLE   = 4'd7,
        OP_READ       = 4'd8
    } op_t;

    // Last part index of the multi-part commands.
    localparam logic [PART_W-1:0] ROUND_LINE_LAST = 3'd3;
    localparam logic [PART_W-1:0] ROUND_FILL_LAST = 3'd5;

    // Drawing primitive that one command part maps to.
    typedef enum logic [2:0] {
        PR_NONE,
        PR_PIXEL,
        PR_BOX,
        PR_DISC,
        PR_LINE,
        PR_TRI,
        PR_READ
    } prim_t;

    // One latched command item.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [FLD_W-1:0]   x_a;
        logic [FLD_W-1:0]   y_a;
        logic [FLD_W-1:0]   x_b;
        logic [FLD_W-1:0]   y_b;
        logic [FLD_W-1:0]   x_c;
        logic [FLD_W-1:0]   y_c;
        logic [FLD_W-1:0]   size_w;
        logic [FLD_W-1:0]   size_h;
        logic [RAD_W-1:0]   radius;
        logic [COLOR_W-1:0] color;
    } draw_cmd_t;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        DC_NONE,
        DC_CLEAR_STEP,
        DC_LOAD,
        DC_SETUP,
        DC_INIT,
        DC_NEXT_PART,
        DC_PIXEL,
        DC_BOX_ROW,
        DC_SPAN_STEP,
        DC_DISC_SKIP,
        DC_ROOT_INIT,
        DC_ROOT_STEP,
        DC_DISC_SPAN,
        DC_LINE_STEP,
        DC_TRI_ROW,
        DC_TRI_SKIP,
        DC_DIV_START,
        DC_TRI_MUL,
        DC_TRI_ACC,
        DC_TRI_SPAN,
        DC_TRI_SKIP_ROW,
        DC_READ,
        DC_READ_CAP
    } dp_cmd_t;

    // Datapath status seen by the controller.
    typedef struct packed {
        prim_t prim;
        logic  last_part;
        logic  clr_last;
        logic  box_more;
        logic  span_more;
        logic  disc_more;
        logic  disc_on;
        logic  root_done;
        logic  line_end;
        logic  tri_more;
        logic  edges_done;
        logic  edge_cov;
        logic  edge_flat;
        logic  tri_n2;
        logic  div_busy;
    } dp_stat_t;

    // Controller states.
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_INIT,
        ST_PIXEL,
        ST_BOX_ROW,
        ST_SPAN,
        ST_DISC_ROW,
        ST_ROOT,
        ST_LINE,
        ST_TRI_ROW,
        ST_TRI_EDGE,
        ST_TRI_DIV,
        ST_TRI_ACC,
        ST_READ,
        ST_READ_WAIT,
        ST_NEXT,
        ST_DONE
    } state_t;

    // Sign-extend a 12-bit field to coordinate width.
    function automatic crd_t sx_fld(input logic [FLD_W-1:0] v);
        return crd_t'($signed(v));
    endfunction

    function automatic crd_t cmax(input crd_t a, input crd_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic crd_t cmin(input crd_t a, input crd_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic on_screen(input crd_t x, input crd_t y);
        return (x >= 0) && (y >= 0) && (x < crd_t'(SCREEN_W)) && (y < crd_t'(SCREEN_H));
    endfunction

    // Linear frame store address; only valid for on-screen points.
    function automatic addr_t pix_addr(input crd_t x, input crd_t y);
        return addr_t'(y) * addr_t'(SCREEN_W) + addr_t'(x);
    endfunction

    // True when row y lies between the edge end rows ay and by, both inclusive.
    function automatic logic covers(input crd_t ay, input crd_t by, input crd_t y);
        return ((ay <= y) && (y <= by)) || ((by <= y) && (y <= ay));
    endfunction

endpackage

FILE: hw/rtl/rdde_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Holds the frame store; no package dependency.
module rdde_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/rdde_div.sv
// Restoring divider for the Q16 triangle edge crossings, one quotient bit a cycle.
// Depends on rdde_pkg.
module rdde_div
    import rdde_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [FLD_W-1:0]  num,
    input  logic [FLD_W-1:0]  den,
    output logic              busy,
    output logic [DIVN_W-1:0] quo
);

    localparam int CNT_W = $clog2(DIVN_W + 1);

    logic [FLD_W:0]    rem_reg, rem_next;
    logic [DIVN_W-1:0] quo_reg, quo_next;
    logic [FLD_W-1:0]  den_reg, den_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [FLD_W:0]    shifted;
    logic [FLD_W:0]    trial;

    // One shift-and-subtract step per cycle; the dividend is num shifted up by 16.
    always_comb begin
        shifted   = {rem_reg[FLD_W-1:0], quo_reg[DIVN_W-1]};
        trial     = shifted - {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = {num, FRAC_W'(0)};
            den_next  = den;
            cnt_next  = CNT_W'(DIVN_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, den_reg}) begin
                rem_next = trial;
                quo_next = {quo_reg[DIVN_W-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[DIVN_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

FILE: hw/rtl/rdde_dp.sv
// Datapath of the draw engine: command registers, shape walkers and the frame store.
// Depends on rdde_pkg, rdde_ram and rdde_div.
module rdde_dp
    import rdde_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  dp_cmd_t   cmd,
    input  draw_cmd_t item,
    output dp_stat_t  stat,
    output color_t    rd_value
);

    // Latched command and part counter.
    draw_cmd_t          it_reg, it_next;
    logic [PART_W-1:0]  part_reg, part_next;
    addr_t              clr_reg, clr_next;

    // Primitive parameters.
    crd_t p_x0_reg, p_x0_next, p_y0_reg, p_y0_next;
    crd_t p_x1_reg, p_x1_next, p_y1_reg, p_y1_next;

    // Row walker and span walker.
    crd_t row_reg, row_next, row_end_reg, row_end_next;
    crd_t span_x_reg, span_x_next, span_end_reg, span_end_next, span_y_reg, span_y_next;

    // Disc state.
    crd_t             dy_reg, dy_next;
    logic [SQ_W-1:0]  rr_reg, rr_next, v_reg, v_next;
    logic [RAD_W-1:0] lo_reg, lo_next, hi_reg, hi_next;

    // Line state.
    crd_t                    lx_reg, lx_next, ly_reg, ly_next;
    logic signed [ERR_W-1:0] ldx_reg, ldx_next, ldy_reg, ldy_next, err_reg, err_next;
    logic                    stx_reg, stx_next, sty_reg, sty_next;

    // Triangle state.
    logic [1:0] edge_reg, edge_next, n_reg, n_next;
    qx_t        qlo_reg, qlo_next, qhi_reg, qhi_next, prod_reg, prod_next;

    // Read-back.
    color_t rv_reg, rv_next;
    logic   rd_on_reg, rd_on_next;

    // Decoded command fields.
    crd_t xa, ya, xb, yb, xc, yc, cw, ch, rad;
    assign xa  = sx_fld(it_reg.x_a);
    assign ya  = sx_fld(it_reg.y_a);
    assign xb  = sx_fld(it_reg.x_b);
    assign yb  = sx_fld(it_reg.y_b);
    assign xc  = sx_fld(it_reg.x_c);
    assign yc  = sx_fld(it_reg.y_c);
    assign cw  = sx_fld(it_reg.size_w);
    assign ch  = sx_fld(it_reg.size_h);
    assign rad = crd_t'(it_reg.radius);

    // Map the command and part index to a primitive and its parameters.
    prim_t prim;
    logic  last_part;
    crd_t  s_x0, s_y0, s_x1, s_y1;

    always_comb begin
        prim      = PR_NONE;
        last_part = 1'b1;
        s_x0      = xa;
        s_y0      = ya;
        s_x1      = xb;
        s_y1      = yb;
        case (it_reg.op)
            OP_PIXEL: begin
                prim = PR_PIXEL;
            end
            OP_RECT: begin
                prim = PR_BOX;
                s_x1 = cw;
                s_y1 = ch;
            end
            OP_SCREEN: begin
                prim = PR_BOX;
                s_x0 = '0;
                s_y0 = '0;
                s_x1 = crd_t'(SCREEN_W);
                s_y1 = crd_t'(SCREEN_H);
            end
            OP_CIRCLE: begin
                prim = PR_DISC;
            end
            OP_LINE: begin
                prim = PR_LINE;
            end
            OP_ROUND_LINE: begin
                prim      = PR_LINE;
                last_part = (part_reg == ROUND_LINE_LAST);
                case (part_reg)
                    3'd0: begin
                        s_x0 = xa + rad;
                        s_y0 = ya;
                        s_x1 = xa + cw - rad;
                        s_y1 = ya;
                    end
                    3'd1: begin
                        s_x0 = xa + rad;
                        s_y0 = ya + ch - crd_t'(1);
                        s_x1 = xa + cw - rad;
                        s_y1 = ya + ch - crd_t'(1);
                    end
                    3'd2: begin
                        s_x0 = xa;
                        s_y0 = ya + rad;
                        s_x1 = xa;
                        s_y1 = ya + ch - rad;
                    end
                    default: begin
                        s_x0 = xa + cw - crd_t'(1);
                        s_y0 = ya + rad;
                        s_x1 = xa + cw - crd_t'(1);
                        s_y1 = ya + ch - rad;
                    end
                endcase
            end
            OP_ROUND_FILL: begin
                last_part = (part_reg == ROUND_FILL_LAST);
                case (part_reg)
                    3'd0: begin
                        prim = PR_BOX;
                        s_x0 = xa + rad;
                        s_y0 = ya;
                        s_x1 = cw - (rad <<< 1);
                        s_y1 = ch;
                    end
                    3'd1: begin
                        prim = PR_BOX;
                        s_x0 = xa;
                        s_y0 = ya + rad;
                        s_x1 = cw;
                        s_y1 = ch - (rad <<< 1);
                    end
                    3'd2: begin
                        prim = PR_DISC;
                        s_x0 = xa + rad;
                        s_y0 = ya + rad;
                    end
                    3'd3: begin
                        prim = PR_DISC;
                        s_x0 = xa + cw - rad - crd_t'(1);
                        s_y0 = ya + rad;
                    end
                    3'd4: begin
                        prim = PR_DISC;
                        s_x0 = xa + rad;
                        s_y0 = ya + ch - rad - crd_t'(1);
                    end
                    default: begin
                        prim = PR_DISC;
                        s_x0 = xa + cw - rad - crd_t'(1);
                        s_y0 = ya + ch - rad - crd_t'(1);
                    end
                endcase
            end
            OP_TRIANGLE: begin
                prim = PR_TRI;
            end
            OP_READ: begin
                prim = PR_READ;
            end
            default: begin
                prim = PR_NONE;
            end
        endcase
    end

    // Current triangle edge, taken in the order ab, bc, ca.
    crd_t ea_x, ea_y, eb_x, eb_y;
    always_comb begin
        case (edge_reg)
            2'd0: begin
                ea_x = xa; ea_y = ya; eb_x = xb; eb_y = yb;
            end
            2'd1: begin
                ea_x = xb; ea_y = yb; eb_x = xc; eb_y = yc;
            end
            default: begin
                ea_x = xc; ea_y = yc; eb_x = xa; eb_y = ya;
            end
        endcase
    end

    // Divider for the edge parameter t = |y - ay| * 2^16 / |by - ay|.
    crd_t              dnum_s, dden_s;
    logic              div_busy;
    logic [DIVN_W-1:0] div_quo;
    assign dnum_s = row_reg - ea_y;
    assign dden_s = eb_y - ea_y;

    rdde_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd == DC_DIV_START),
        .num     (FLD_W'((dnum_s < 0) ? -dnum_s : dnum_s)),
        .den     (FLD_W'((dden_s < 0) ? -dden_s : dden_s)),
        .busy    (div_busy),
        .quo     (div_quo)
    );

    // Frame store.
    logic   ram_we, ram_re;
    addr_t  ram_waddr, ram_raddr;
    color_t ram_wdata, ram_rdata;

    rdde_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PIX_N)
    ) u_frame (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Helper values for the walkers.
    logic signed [ERR_W-1:0]       e2, ldx_i, ldy_i;
    logic [RAD_W:0]                mid_sum;
    logic [RAD_W-1:0]              mid, ady;
    logic [SQ_W-1:0]               mid_sq;
    logic signed [CRD_W+FRAC_W+1:0] tprod;
    qx_t                           xq, qdiff;
    crd_t                          t_start, t_len, drow, m_crd;

    always_comb begin
        e2      = err_reg <<< 1;
        ldx_i   = ERR_W'(p_x1_reg) - ERR_W'(p_x0_reg);
        ldy_i   = ERR_W'(p_y1_reg) - ERR_W'(p_y0_reg);
        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + 1'b1;
        mid     = mid_sum[RAD_W:1];
        mid_sq  = mid * mid;
        ady     = RAD_W'((dy_reg < 0) ? -dy_reg : dy_reg);
        tprod   = (eb_x - ea_x) * $signed({1'b0, div_quo[FRAC_W:0]});
        xq      = (qx_t'(ea_x) <<< FRAC_W) + (stat.edge_flat ? qx_t'(0) : prod_reg);
        qdiff   = qhi_reg - qlo_reg;
        t_start = crd_t'(qlo_reg >>> FRAC_W)
                + ((qlo_reg < 0 && qlo_reg[FRAC_W-1:0] != '0) ? crd_t'(1) : crd_t'(0));
        t_len   = crd_t'(qdiff >>> FRAC_W);
        drow    = p_y0_reg + dy_reg;
        m_crd   = crd_t'(lo_reg);
    end

    // Status toward the controller.
    always_comb begin
        stat.prim       = prim;
        stat.last_part  = last_part;
        stat.clr_last   = (clr_reg == addr_t'(PIX_N - 1));
        stat.box_more   = (row_reg < row_end_reg);
        stat.span_more  = (span_x_reg <= span_end_reg);
        stat.disc_more  = (dy_reg <= rad);
        stat.disc_on    = (drow >= 0) && (drow < crd_t'(SCREEN_H));
        stat.root_done  = (lo_reg == hi_reg);
        stat.line_end   = (lx_reg == p_x1_reg) && (ly_reg == p_y1_reg);
        stat.tri_more   = (row_reg <= row_end_reg);
        stat.edges_done = (edge_reg == 2'd3);
        stat.edge_cov   = covers(ea_y, eb_y, row_reg);
        stat.edge_flat  = (ea_y == eb_y);
        stat.tri_n2     = (n_reg >= 2'd2);
        stat.div_busy   = div_busy;
    end

    // Next-state logic of all datapath registers and the frame store ports.
    always_comb begin
        it_next       = it_reg;
        part_next     = part_reg;
        clr_next      = clr_reg;
        p_x0_next     = p_x0_reg;
        p_y0_next     = p_y0_reg;
        p_x1_next     = p_x1_reg;
        p_y1_next     = p_y1_reg;
        row_next      = row_reg;
        row_end_next  = row_end_reg;
        span_x_next   = span_x_reg;
        span_end_next = span_end_reg;
        span_y_next   = span_y_reg;
        dy_next       = dy_reg;
        rr_next       = rr_reg;
        v_next        = v_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        lx_next       = lx_reg;
        ly_next       = ly_reg;
        ldx_next      = ldx_reg;
        ldy_next      = ldy_reg;
        err_next      = err_reg;
        stx_next      = stx_reg;
        sty_next      = sty_reg;
        edge_next     = edge_reg;
        n_next        = n_reg;
        qlo_next      = qlo_reg;
        qhi_next      = qhi_reg;
        prod_next     = prod_reg;
        rv_next       = rv_reg;
        rd_on_next    = rd_on_reg;
        ram_we        = 1'b0;
        ram_waddr     = pix_addr(span_x_reg, span_y_reg);
        ram_wdata     = it_reg.color;
        ram_re        = 1'b0;
        ram_raddr     = pix_addr(xa, ya);

        case (cmd)
            DC_CLEAR_STEP: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            DC_LOAD: begin
                it_next   = item;
                part_next = '0;
                rv_next   = '0;
            end
            DC_SETUP: begin
                p_x0_next = s_x0;
                p_y0_next = s_y0;
                p_x1_next = s_x1;
                p_y1_next = s_y1;
            end
            DC_INIT: begin
                // Box rows run from max(y,0) up to min(y+h,H), exclusive.
                if (prim == PR_BOX) begin
                    row_next     = cmax(p_y0_reg, '0);
                    row_end_next = cmin(p_y0_reg + p_y1_reg, crd_t'(SCREEN_H));
                end
                if (prim == PR_TRI) begin
                    row_next     = cmax(cmin(cmin(ya, yb), yc), '0);
                    row_end_next = cmin(cmax(cmax(ya, yb), yc), crd_t'(SCREEN_H - 1));
                end
                dy_next  = -rad;
                rr_next  = it_reg.radius * it_reg.radius;
                lx_next  = p_x0_reg;
                ly_next  = p_y0_reg;
                ldx_next = (ldx_i < 0) ? -ldx_i : ldx_i;
                ldy_next = (ldy_i < 0) ? ldy_i : -ldy_i;
                err_next = ((ldx_i < 0) ? -ldx_i : ldx_i) + ((ldy_i < 0) ? ldy_i : -ldy_i);
                stx_next = (p_x0_reg < p_x1_reg);
                sty_next = (p_y0_reg < p_y1_reg);
            end
            DC_NEXT_PART: begin
                part_next = part_reg + 1'b1;
            end
            DC_PIXEL: begin
                ram_we    = on_screen(p_x0_reg, p_y0_reg);
                ram_waddr = pix_addr(p_x0_reg, p_y0_reg);
            end
            DC_BOX_ROW: begin
                span_x_next   = cmax(p_x0_reg, '0);
                span_end_next = cmin(p_x0_reg + p_x1_reg - crd_t'(1), crd_t'(SCREEN_W - 1));
                span_y_next   = row_reg;
                row_next      = row_reg + crd_t'(1);
            end
            DC_SPAN_STEP: begin
                ram_we      = stat.span_more;
                span_x_next = span_x_reg + crd_t'(1);
            end
            DC_DISC_SKIP: begin
                dy_next = dy_reg + crd_t'(1);
            end
            DC_ROOT_INIT: begin
                v_next  = rr_reg - ady * ady;
                lo_next = '0;
                hi_next = '1;
            end
            DC_ROOT_STEP: begin
                // Binary search for the largest m with m*m <= r*r - dy*dy.
                if (mid_sq <= v_reg) begin
                    lo_next = mid;
                end else begin
                    hi_next = mid - 1'b1;
                end
            end
            DC_DISC_SPAN: begin
                span_x_next   = cmax(p_x0_reg - m_crd, '0);
                span_end_next = cmin(p_x0_reg + m_crd, crd_t'(SCREEN_W - 1));
                span_y_next   = drow;
                dy_next       = dy_reg + crd_t'(1);
            end
            DC_LINE_STEP: begin
                ram_we    = on_screen(lx_reg, ly_reg);
                ram_waddr = pix_addr(lx_reg, ly_reg);
                if (!stat.line_end) begin
                    // Both error tests use the error value before this step.
                    err_next = err_reg
                             + ((e2 >= ldy_reg) ? ldy_reg : ERR_W'(0))
                             + ((e2 <= ldx_reg) ? ldx_reg : ERR_W'(0));
                    if (e2 >= ldy_reg) begin
                        lx_next = stx_reg ? lx_reg + crd_t'(1) : lx_reg - crd_t'(1);
                    end
                    if (e2 <= ldx_reg) begin
                        ly_next = sty_reg ? ly_reg + crd_t'(1) : ly_reg - crd_t'(1);
                    end
                end
            end
            DC_TRI_ROW: begin
                edge_next = '0;
                n_next    = '0;
            end
            DC_TRI_SKIP: begin
                edge_next = edge_reg + 1'b1;
            end
            DC_TRI_MUL: begin
                prod_next = qx_t'(tprod);
            end
            DC_TRI_ACC: begin
                // Keep the running minimum and maximum of the edge crossings.
                if (n_reg == 2'd0) begin
                    qlo_next = xq;
                    qhi_next = xq;
                end else begin
                    qlo_next = (xq < qlo_reg) ? xq : qlo_reg;
                    qhi_next = (xq > qhi_reg) ? xq : qhi_reg;
                end
                n_next    = n_reg + 1'b1;
                edge_next = edge_reg + 1'b1;
            end
            DC_TRI_SPAN: begin
                span_x_next   = cmax(t_start, '0);
                span_end_next = cmin(t_start + t_len, crd_t'(SCREEN_W - 1));
                span_y_next   = row_reg;
                row_next      = row_reg + crd_t'(1);
            end
            DC_TRI_SKIP_ROW: begin
                row_next = row_reg + crd_t'(1);
            end
            DC_READ: begin
                ram_re     = on_screen(xa, ya);
                rd_on_next = on_screen(xa, ya);
            end
            DC_READ_CAP: begin
                rv_next = rd_on_reg ? ram_rdata : '0;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_reg <= '0;
            clr_reg  <= '0;
            edge_reg <= '0;
            n_reg    <= '0;
        end else begin
            part_reg <= part_next;
            clr_reg  <= clr_next;
            edge_reg <= edge_next;
            n_reg    <= n_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        it_reg       <= it_next;
        p_x0_reg     <= p_x0_next;
        p_y0_reg     <= p_y0_next;
        p_x1_reg     <= p_x1_next;
        p_y1_reg     <= p_y1_next;
        row_reg      <= row_next;
        row_end_reg  <= row_end_next;
        span_x_reg   <= span_x_next;
        span_end_reg <= span_end_next;
        span_y_reg   <= span_y_next;
        dy_reg       <= dy_next;
        rr_reg       <= rr_next;
        v_reg        <= v_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        lx_reg       <= lx_next;
        ly_reg       <= ly_next;
        ldx_reg      <= ldx_next;
        ldy_reg      <= ldy_next;
        err_reg      <= err_next;
        stx_reg      <= stx_next;
        sty_reg      <= sty_next;
        qlo_reg      <= qlo_next;
        qhi_reg      <= qhi_next;
        prod_reg     <= prod_next;
        rv_reg       <= rv_next;
        rd_on_reg    <= rd_on_next;
    end

    assign rd_value = rv_reg;

endmodule

FILE: hw/rtl/rdde_ctrl.sv
// Controller state machine of the draw engine: sequences the datapath per command.
// Depends on rdde_pkg.
module rdde_ctrl
    import rdde_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     out_free,
    output logic     out_load,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = DC_NONE;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd = DC_CLEAR_STEP;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd        = DC_LOAD;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd        = DC_SETUP;
                state_next = ST_INIT;
            end
            ST_INIT: begin
                cmd = DC_INIT;
                case (stat.prim)
                    PR_PIXEL: state_next = ST_PIXEL;
                    PR_BOX:   state_next = ST_BOX_ROW;
                    PR_DISC:  state_next = ST_DISC_ROW;
                    PR_LINE:  state_next = ST_LINE;
                    PR_TRI:   state_next = ST_TRI_ROW;
                    PR_READ:  state_next = ST_READ;
                    default:  state_next = ST_NEXT;
                endcase
            end
            ST_PIXEL: begin
                cmd        = DC_PIXEL;
                state_next = ST_NEXT;
            end
            ST_BOX_ROW: begin
                if (stat.box_more) begin
                    cmd        = DC_BOX_ROW;
                    state_next = ST_SPAN;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_SPAN: begin
                // Write one pixel a cycle, then return to the row loop of the shape.
                if (stat.span_more) begin
                    cmd = DC_SPAN_STEP;
                end else begin
                    case (stat.prim)
                        PR_DISC: state_next = ST_DISC_ROW;
                        PR_TRI:  state_next = ST_TRI_ROW;
                        default: state_next = ST_BOX_ROW;
                    endcase
                end
            end
            ST_DISC_ROW: begin
                if (!stat.disc_more) begin
                    state_next = ST_NEXT;
                end else if (!stat.disc_on) begin
                    cmd = DC_DISC_SKIP;
                end else begin
                    cmd        = DC_ROOT_INIT;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (stat.root_done) begin
                    cmd        = DC_DISC_SPAN;
                    state_next = ST_SPAN;
                end else begin
                    cmd = DC_ROOT_STEP;
                end
            end
            ST_LINE: begin
                cmd = DC_LINE_STEP;
                if (stat.line_end) begin
                    state_next = ST_NEXT;
                end
            end
            ST_TRI_ROW: begin
                if (stat.tri_more) begin
                    cmd        = DC_TRI_ROW;
                    state_next = ST_TRI_EDGE;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_TRI_EDGE: begin
                if (stat.edges_done) begin
                    if (stat.tri_n2) begin
                        cmd        = DC_TRI_SPAN;
                        state_next = ST_SPAN;
                    end else begin
                        cmd        = DC_TRI_SKIP_ROW;
                        state_next = ST_TRI_ROW;
                    end
                end else if (!stat.edge_cov) begin
                    cmd = DC_TRI_SKIP;
                end else if (stat.edge_flat) begin
                    cmd = DC_TRI_ACC;
                end else begin
                    cmd        = DC_DIV_START;
                    state_next = ST_TRI_DIV;
                end
            end
            ST_TRI_DIV: begin
                if (!stat.div_busy) begin
                    cmd        = DC_TRI_MUL;
                    state_next = ST_TRI_ACC;
                end
            end
            ST_TRI_ACC: begin
                cmd        = DC_TRI_ACC;
                state_next = ST_TRI_EDGE;
            end
            ST_READ: begin
                cmd        = DC_READ;
                state_next = ST_READ_WAIT;
            end
            ST_READ_WAIT: begin
                cmd        = DC_READ_CAP;
                state_next = ST_NEXT;
            end
            ST_NEXT: begin
                if (stat.last_part) begin
                    state_next = ST_DONE;
                end else begin
                    cmd        = DC_NEXT_PART;
                    state_next = ST_SETUP;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/raster_2d_draw_engine_top.sv
// Top level of the raster draw engine: stream ports, result register and assertions.
// Depends on rdde_pkg, rdde_ctrl and rdde_dp.

// Command-driven 2D drawing engine over an internal 320x240 RGB565 frame store.
// After reset the frame store is cleared by a pass of one pixel per cycle, during
// which s_tready stays low. Each command item (op in s_tuser) draws into or reads
// the frame store and returns one result item: the read pixel for a read command,
// zero otherwise. One command is worked on at a time. Each shape part is set up
// first; spans and lines then write one pixel per cycle through the single frame
// store write port. A circle row adds a square-root search, and a triangle row
// runs the serial divider for each sloped edge that it crosses. A finished result
// waits in an output register while the next command is accepted.
module raster_2d_draw_engine_top
    import rdde_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // x_a[11:0], y_a[23:12], x_b[35:24], y_b[47:36], x_c[59:48], y_c[71:60],
    // size_w[83:72], size_h[95:84], radius[105:96], color[121:106], zeros above
    input  logic [127:0] s_tdata,
    // op[3:0]
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // read_value[15:0]
    output logic [15:0]  m_tdata
);

    draw_cmd_t item;
    dp_cmd_t   cmd;
    dp_stat_t  stat;
    color_t    rd_value;
    logic      out_load, out_free;
    logic      m_tvalid_reg, m_tvalid_next;
    color_t    m_tdata_reg, m_tdata_next;

    // Unpack the incoming item.
    always_comb begin
        item.op     = s_tuser;
        item.x_a    = s_tdata[11:0];
        item.y_a    = s_tdata[23:12];
        item.x_b    = s_tdata[35:24];
        item.y_b    = s_tdata[47:36];
        item.x_c    = s_tdata[59:48];
        item.y_c    = s_tdata[71:60];
        item.size_w = s_tdata[83:72];
        item.size_h = s_tdata[95:84];
        item.radius = s_tdata[105:96];
        item.color  = s_tdata[121:106];
    end

    rdde_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .out_free (out_free),
        .out_load (out_load),
        .stat     (stat),
        .cmd      (cmd)
    );

    rdde_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .item     (item),
        .stat     (stat),
        .rd_value (rd_value)
    );

    // Result register between the engine and the output stream.
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = rd_value;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    // A result is only loaded when the output register is free.
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over a pending result");

    // An accepted item is worked on before the next one is taken.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a command is in progress");

    // The divider is never restarted while it is still running.
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == DC_DIV_START) |-> !stat.div_busy)
        else $error("divider started while busy");
`endif

endmodule

FILE: tb/raster_2d_draw_engine_top_tb.sv
// Self-checking testbench for raster_2d_draw_engine_top: a directed table, then random commands.
// It keeps its own copy of the frame store and predicts every result item.
// Depends on rdde_pkg and the RTL of the block only.
module raster_2d_draw_engine_top_tb;
    import rdde_pkg::*;

    // One command item as it is driven on the input channel.
    typedef struct {
        logic [3:0]  op;
        logic [11:0] x_a, y_a, x_b, y_b, x_c, y_c, size_w, size_h;
        logic [9:0]  radius;
        logic [15:0] color;
        bit          has_fixed;   // the expected read value is typed in
        logic [15:0] fixed_val;
    } draw_item_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [3:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [15:0]  m_tdata;

    // Shadow of the frame store and the queue of expected read values.
    logic [15:0] shadow_fb [SCREEN_W*SCREEN_H];
    logic [15:0] pending_reads [$];
    draw_item_t  directed_rows [$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int results_seen;
    int items_sent;
    int op_hits [16];

    raster_2d_draw_engine_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog: far above the slowest correct run.
    initial begin
        #200000000;
        $display("simulation failed");
        $finish;
    end

    // Frame store predictor: primitives that write the shadow copy.
    function automatic void put_pixel(int x, int y, logic [15:0] c);
        if (x < 0 || y < 0 || x >= SCREEN_W || y >= SCREEN_H) return;
        shadow_fb[y*SCREEN_W + x] = c;
    endfunction

    function automatic void put_span(int xl, int xr, int y, logic [15:0] c);
        if (y < 0 || y >= SCREEN_H) return;
        if (xl < 0) xl = 0;
        if (xr > SCREEN_W - 1) xr = SCREEN_W - 1;
        for (int x = xl; x <= xr; x++) shadow_fb[y*SCREEN_W + x] = c;
    endfunction

    function automatic void put_box(int x, int y, int w, int h, logic [15:0] c);
        int top;
        int bot;
        top = (y < 0) ? 0 : y;
        bot = (y + h > SCREEN_H) ? SCREEN_H : y + h;
        for (int row = top; row < bot; row++) put_span(x, x + w - 1, row, c);
    endfunction

    function automatic int isqrt_floor(int v);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = 1023;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic void put_disc(int cx, int cy, int r, logic [15:0] c);
        int half;
        for (int dy = -r; dy <= r; dy++) begin
            if (cy + dy >= 0 && cy + dy < SCREEN_H) begin
                half = isqrt_floor(r * r - dy * dy);
                put_span(cx - half, cx + half, cy + dy, c);
            end
        end
    endfunction

    // Bresenham line, both ends inclusive.
    function automatic void put_line(int x0, int y0, int x1, int y1, logic [15:0] c);
        int dx;
        int dy;
        int sx;
        int sy;
        int err;
        int e2;
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = -((y1 > y0) ? y1 - y0 : y0 - y1);
        sx = (x0 < x1) ? 1 : -1;
        sy = (y0 < y1) ? 1 : -1;
        err = dx + dy;
        forever begin
            put_pixel(x0, y0, c);
            if (x0 == x1 && y0 == y1) break;
            e2 = 2 * err;
            if (e2 >= dy) begin
                err += dy;
                x0 += sx;
            end
            if (e2 <= dx) begin
                err += dx;
                y0 += sy;
            end
        end
    endfunction

    function automatic bit row_between(int ay, int by, int y);
        return (ay <= y && y <= by) || (by <= y && y <= ay);
    endfunction

    // Q16 edge crossing at row y; division truncates toward zero.
    function automatic longint edge_x_q16(int ax, int ay, int bx, int by, int y);
        longint t;
        if (ay == by) return longint'(ax) * 65536;
        t = (longint'(y - ay) * 65536) / longint'(by - ay);
        return longint'(ax) * 65536 + longint'(bx - ax) * t;
    endfunction

    function automatic void put_triangle(int x0, int y0, int x1, int y1,
                                         int x2, int y2, logic [15:0] c);
        int     top;
        int     bot;
        int     hits;
        int     start;
        int     len;
        longint xq;
        longint lo;
        longint hi;
        top = y0;
        bot = y0;
        if (y1 < top) top = y1;
        if (y2 < top) top = y2;
        if (y1 > bot) bot = y1;
        if (y2 > bot) bot = y2;
        if (top < 0) top = 0;
        if (bot > SCREEN_H - 1) bot = SCREEN_H - 1;
        for (int y = top; y <= bot; y++) begin
            hits = 0;
            for (int e = 0; e < 3; e++) begin
                int ax;
                int ay;
                int bx;
                int by;
                ax = (e == 0) ? x0 : (e == 1) ? x1 : x2;
                ay = (e == 0) ? y0 : (e == 1) ? y1 : y2;
                bx = (e == 0) ? x1 : (e == 1) ? x2 : x0;
                by = (e == 0) ? y1 : (e == 1) ? y2 : y0;
                if (row_between(ay, by, y)) begin
                    xq = edge_x_q16(ax, ay, bx, by, y);
                    if (hits == 0) begin
                        lo = xq;
                        hi = xq;
                    end else begin
                        if (xq < lo) lo = xq;
                        if (xq > hi) hi = xq;
                    end
                    hits++;
                end
            end
            if (hits >= 2) begin
                start = int'(lo / 65536);
                len = int'((hi - lo) / 65536) + 1;
                put_span(start, start + len - 1, y, c);
            end
        end
    endfunction

    // Apply one command to the shadow frame store and return its result value.
    function automatic logic [15:0] apply_command(draw_item_t it);
        int xa, ya, xb, yb, xc, yc, w, h, r;
        logic [15:0] c;
        xa = int'($signed(it.x_a));
        ya = int'($signed(it.y_a));
        xb = int'($signed(it.x_b));
        yb = int'($signed(it.y_b));
        xc = int'($signed(it.x_c));
        yc = int'($signed(it.y_c));
        w  = int'($signed(it.size_w));
        h  = int'($signed(it.size_h));
        r  = int'(it.radius);
        c  = it.color;
        case (it.op)
            OP_PIXEL:  put_pixel(xa, ya, c);
            OP_RECT:   put_box(xa, ya, w, h, c);
            OP_SCREEN: put_box(0, 0, SCREEN_W, SCREEN_H, c);
            OP_CIRCLE: put_disc(xa, ya, r, c);
            OP_LINE:   put_line(xa, ya, xb, yb, c);
            OP_ROUND_LINE: begin
                put_line(xa + r, ya, xa + w - r, ya, c);
                put_line(xa + r, ya + h - 1, xa + w - r, ya + h - 1, c);
                put_line(xa, ya + r, xa, ya + h - r, c);
                put_line(xa + w - 1, ya + r, xa + w - 1, ya + h - r, c);
            end
            OP_ROUND_FILL: begin
                put_box(xa + r, ya, w - 2 * r, h, c);
                put_box(xa, ya + r, w, h - 2 * r, c);
                put_disc(xa + r, ya + r, r, c);
                put_disc(xa + w - r - 1, ya + r, r, c);
                put_disc(xa + r, ya + h - r - 1, r, c);
                put_disc(xa + w - r - 1, ya + h - r - 1, r, c);
            end
            OP_TRIANGLE: put_triangle(xa, ya, xb, yb, xc, yc, c);
            OP_READ: begin
                if (xa >= 0 && ya >= 0 && xa < SCREEN_W && ya < SCREEN_H)
                    return shadow_fb[ya*SCREEN_W + xa];
            end
            default: ;
        endcase
        return 16'h0000;
    endfunction

    // Drive one item from the falling edge and wait for its handshake.
    task automatic send_item(draw_item_t it);
        logic [15:0] want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = it.op;
        s_tdata  = {6'b0, it.color, it.radius, it.size_h, it.size_w,
                    it.y_c, it.x_c, it.y_b, it.x_b, it.y_a, it.x_a};
        do @(posedge aclk); while (!s_tready);
        want = apply_command(it);
        if (it.has_fixed) want = it.fixed_val;
        pending_reads.push_back(want);
        op_hits[it.op]++;
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic add_row(logic [3:0] op, int xa, int ya, int xb, int yb, int xc, int yc,
                           int w, int h, int r, int c, bit fixed, int val);
        draw_item_t it;
        it.op = op;
        it.x_a = xa[11:0];
        it.y_a = ya[11:0];
        it.x_b = xb[11:0];
        it.y_b = yb[11:0];
        it.x_c = xc[11:0];
        it.y_c = yc[11:0];
        it.size_w = w[11:0];
        it.size_h = h[11:0];
        it.radius = r[9:0];
        it.color = c[15:0];
        it.has_fixed = fixed;
        it.fixed_val = val[15:0];
        directed_rows.push_back(it);
    endtask

    // Mostly small shapes near the screen; now and then full-range fields.
    function automatic draw_item_t random_item();
        draw_item_t it;
        bit wide;
        int pick;
        wide = ($urandom_range(31) == 0);
        pick = $urandom_range(99);
        if (pick < 28)      it.op = OP_READ;
        else if (pick < 40) it.op = OP_PIXEL;
        else if (pick < 50) it.op = OP_RECT;
        else if (pick < 60) it.op = OP_CIRCLE;
        else if (pick < 71) it.op = OP_LINE;
        else if (pick < 79) it.op = OP_ROUND_LINE;
        else if (pick < 87) it.op = OP_ROUND_FILL;
        else if (pick < 96) it.op = OP_TRIANGLE;
        else if (pick < 99) it.op = 4'($urandom_range(15, 9));
        else                it.op = ($urandom_range(3) == 0) ? OP_SCREEN : OP_READ;
        if (wide) begin
            {it.x_a, it.y_a, it.x_b, it.y_b} = 48'({$urandom, $urandom});
            {it.x_c, it.y_c, it.size_w, it.size_h} = 48'({$urandom, $urandom});
            it.radius = 10'($urandom);
        end else begin
            it.x_a = 12'($urandom_range(SCREEN_W + 40) - 20);
            it.y_a = 12'($urandom_range(SCREEN_H + 40) - 20);
            it.x_b = 12'(int'($signed(it.x_a)) + $urandom_range(60) - 30);
            it.y_b = 12'(int'($signed(it.y_a)) + $urandom_range(60) - 30);
            it.x_c = 12'(int'($signed(it.x_a)) + $urandom_range(60) - 30);
            it.y_c = 12'(int'($signed(it.y_a)) + $urandom_range(60) - 30);
            it.size_w = 12'($urandom_range(44) - 4);
            it.size_h = 12'($urandom_range(44) - 4);
            it.radius = 10'($urandom_range(20));
        end
        it.color = 16'($urandom);
        it.has_fixed = 1'b0;
        it.fixed_val = '0;
        return it;
    endfunction

    // Receiver stalls, changed at the falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker: compare each accepted item with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_reads.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item read_value=%h", m_tdata);
            end else begin
                logic [15:0] want;
                want = pending_reads.pop_front();
                if (m_tdata !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: read_value expected %h, got %h",
                                 results_seen, want, m_tdata);
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int guard;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        send_idle_pct = 11;
        recv_idle_pct = 73;
        for (int i = 0; i < SCREEN_W*SCREEN_H; i++) shadow_fb[i] = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed rows: corners, extremes, every command and the odd cases.
        add_row(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 16'h0000);
        add_row(OP_READ, 319, 239, 0, 0, 0, 0, 0, 0, 0, 0, 1, 16'h0000);
        add_row(OP_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 1, 0);
        add_row(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 16'hFFFF);
        add_row(OP_PIXEL, -1, 5, 0, 0, 0, 0, 0, 0, 0, 16'h1234, 1, 0);
        add_row(OP_READ, -1, 5, 0, 0, 0, 0, 0, 0, 0, 0, 1, 16'h0000);
        add_row(OP_READ, 2047, 2047, 0, 0, 0, 0, 0, 0, 0, 0, 1, 16'h0000);
        add_row(OP_READ, -2048, -2048, 0, 0, 0, 0, 0, 0, 0, 0, 1, 16'h0000);
        add_row(OP_SCREEN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'hA5C3, 1, 0);
        add_row(OP_READ, 319, 239, 0, 0, 0, 0, 0, 0, 0, 0, 1, 16'hA5C3);
        add_row(OP_RECT, 310, 230, 0, 0, 0, 0, 20, 20, 0, 16'h0F0F, 0, 0);
        add_row(OP_RECT, 10, 10, 0, 0, 0, 0, -5, 8, 0, 16'h0F0F, 0, 0);
        add_row(OP_READ, 315, 235, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_CIRCLE, 50, 50, 0, 0, 0, 0, 0, 0, 0, 16'h00FF, 0, 0);
        add_row(OP_CIRCLE, 2, 3, 0, 0, 0, 0, 0, 0, 9, 16'h7E0, 0, 0);
        add_row(OP_LINE, -2048, -2048, 2047, 2047, 0, 0, 0, 0, 0, 16'hF800, 0, 0);
        add_row(OP_READ, 100, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_ROUND_LINE, 20, 20, 0, 0, 0, 0, 40, 30, 6, 16'h001F, 0, 0);
        add_row(OP_ROUND_FILL, 100, 40, 0, 0, 0, 0, 10, 30, 8, 16'h3333, 0, 0);
        add_row(OP_TRIANGLE, 200, 10, 230, 40, 180, 60, 0, 0, 0, 16'h5555, 0, 0);
        add_row(OP_TRIANGLE, 200, 100, 240, 100, 220, 100, 0, 0, 0, 16'h6666, 0, 0);
        add_row(OP_READ, 210, 30, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(4'd9, 5, 5, 0, 0, 0, 0, 0, 0, 0, 16'h1111, 1, 0);
        add_row(4'd15, 5, 5, 0, 0, 0, 0, 0, 0, 0, 16'h2222, 1, 0);
        add_row(OP_READ, 5, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        foreach (directed_rows[i]) send_item(directed_rows[i]);

        // Random commands in three idling phases.
        for (int n = 0; n < 1300; n++) begin
            if (n == 430) begin
                send_idle_pct = 73;
                recv_idle_pct = 11;
            end
            if (n == 860) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // Hold the sender off until the block has drained.
                s_tvalid = 1'b0;
                while (pending_reads.size() != 0) @(negedge aclk);
            end
            send_item(random_item());
        end
        s_tvalid = 1'b0;

        guard = 0;
        while (pending_reads.size() != 0 && guard < 2000000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (200) @(negedge aclk);
        if (pending_reads.size() != 0) mismatches++;

        $display("Covered %0d commands (%0d reads, %0d triangles, %0d round fills), %0d results.",
                 items_sent, op_hits[OP_READ], op_hits[OP_TRIANGLE], op_hits[OP_ROUND_FILL],
                 results_seen);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/rdde_pkg.sv
hw/rtl/rdde_ram.sv
hw/rtl/rdde_div.sv
hw/rtl/rdde_dp.sv
hw/rtl/rdde_ctrl.sv
hw/rtl/raster_2d_draw_engine_top.sv
tb/raster_2d_draw_engine_top_tb.sv
